// ===== hdl/sit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the segment intersection test
// Operation codes, orientation sign codes, the cross product wiring table and
// the control structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Point, cross product and difference counts.
  localparam int NUM_PTS       = 4;
  localparam int NUM_CROSS     = 4;
  localparam int DIFF_PER_CRS  = 4;
  localparam int NUM_DIFF      = NUM_CROSS * DIFF_PER_CRS;
  localparam int NUM_PROD      = 2 * NUM_CROSS;

  // Bounding intervals used by the inclusive test.
  localparam int NUM_IV = 4;
  localparam int IV_X12 = 0;
  localparam int IV_X34 = 1;
  localparam int IV_Y12 = 2;
  localparam int IV_Y34 = 3;

  // Each cross product is cross(a - o, b - o); points are numbered p1 = 0.
  localparam logic [1:0] CROSS_O [NUM_CROSS] = '{2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] CROSS_A [NUM_CROSS] = '{2'd2, 2'd2, 2'd0, 2'd0};
  localparam logic [1:0] CROSS_B [NUM_CROSS] = '{2'd3, 2'd3, 2'd1, 2'd1};

  // Port widths that do not depend on the coordinate width.
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_SEG_INCL   = 2'd0,
    OP_SEG_STRICT = 2'd1,
    OP_LINE_SEG   = 2'd2,
    OP_LINE_NPAR  = 2'd3
  } op_t;

  // Two-bit signed orientation codes.
  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  typedef struct packed {
    op_t  op;
    logic ovl_x;
    logic ovl_y;
  } ctrl_t;

  typedef struct packed {
    logic [NUM_CROSS-1:0][1:0] side;
    logic                      c12_eq;
    ctrl_t                     ctrl;
  } sign_info_t;

endpackage

// ===== hdl/sit_diff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_diff: first pipeline stage
// Forms the sixteen coordinate differences of the four cross products and
// the ordered bounds of the four coordinate intervals.
// ----------------------------------------------------------------------------
module sit_diff
  import sit_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  op_t                  up_op,
  input  logic signed [CB-1:0] pt_x [NUM_PTS],
  input  logic signed [CB-1:0] pt_y [NUM_PTS],
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output op_t                  dn_op,
  output logic signed [CB:0]   diff [NUM_DIFF],
  output logic signed [CB-1:0] lo   [NUM_IV],
  output logic signed [CB-1:0] hi   [NUM_IV]
);

  logic                 load;
  logic                 v_r, v_nxt;
  op_t                  op_r;
  logic signed [CB:0]   diff_r [NUM_DIFF];
  logic signed [CB:0]   diff_nxt [NUM_DIFF];
  logic signed [CB-1:0] lo_r [NUM_IV];
  logic signed [CB-1:0] hi_r [NUM_IV];
  logic signed [CB-1:0] lo_nxt [NUM_IV];
  logic signed [CB-1:0] hi_nxt [NUM_IV];
  logic signed [CB-1:0] iv_a [NUM_IV];
  logic signed [CB-1:0] iv_b [NUM_IV];

  assign load     = !v_r || dn_ready;
  assign up_ready = load;
  assign v_nxt    = load ? up_valid : v_r;

  // Differences are taken one bit wider so that they are exact.
  always_comb begin
    for (int k = 0; k < NUM_CROSS; k++) begin
      diff_nxt[DIFF_PER_CRS*k]     = {pt_x[CROSS_A[k]][CB-1], pt_x[CROSS_A[k]]}
                                   - {pt_x[CROSS_O[k]][CB-1], pt_x[CROSS_O[k]]};
      diff_nxt[DIFF_PER_CRS*k + 1] = {pt_y[CROSS_A[k]][CB-1], pt_y[CROSS_A[k]]}
                                   - {pt_y[CROSS_O[k]][CB-1], pt_y[CROSS_O[k]]};
      diff_nxt[DIFF_PER_CRS*k + 2] = {pt_x[CROSS_B[k]][CB-1], pt_x[CROSS_B[k]]}
                                   - {pt_x[CROSS_O[k]][CB-1], pt_x[CROSS_O[k]]};
      diff_nxt[DIFF_PER_CRS*k + 3] = {pt_y[CROSS_B[k]][CB-1], pt_y[CROSS_B[k]]}
                                   - {pt_y[CROSS_O[k]][CB-1], pt_y[CROSS_O[k]]};
    end
  end

  always_comb begin
    iv_a[IV_X12] = pt_x[0];
    iv_b[IV_X12] = pt_x[1];
    iv_a[IV_X34] = pt_x[2];
    iv_b[IV_X34] = pt_x[3];
    iv_a[IV_Y12] = pt_y[0];
    iv_b[IV_Y12] = pt_y[1];
    iv_a[IV_Y34] = pt_y[2];
    iv_b[IV_Y34] = pt_y[3];
    for (int i = 0; i < NUM_IV; i++) begin
      lo_nxt[i] = (iv_a[i] < iv_b[i]) ? iv_a[i] : iv_b[i];
      hi_nxt[i] = (iv_a[i] < iv_b[i]) ? iv_b[i] : iv_a[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= up_op;
      diff_r <= diff_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_op    = op_r;
  assign diff     = diff_r;
  assign lo       = lo_r;
  assign hi       = hi_r;

endmodule

// ===== hdl/sit_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_mult: second pipeline stage
// Forms the eight partial products of the cross products and resolves the
// two interval overlap checks.
// ----------------------------------------------------------------------------
module sit_mult
  import sit_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  op_t                      up_op,
  input  logic signed [CB:0]       diff [NUM_DIFF],
  input  logic signed [CB-1:0]     lo   [NUM_IV],
  input  logic signed [CB-1:0]     hi   [NUM_IV],
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output ctrl_t                    dn_ctrl,
  output logic signed [2*CB+1:0]   prod [NUM_PROD]
);

  localparam int PW = 2 * CB + 2;

  logic                 load;
  logic                 v_r, v_nxt;
  ctrl_t                ctrl_r, ctrl_nxt;
  logic signed [PW-1:0] prod_r [NUM_PROD];
  logic signed [PW-1:0] prod_nxt [NUM_PROD];

  assign load     = !v_r || dn_ready;
  assign up_ready = load;
  assign v_nxt    = load ? up_valid : v_r;

  // cross = ax * by - ay * bx; the even product is ax * by.
  always_comb begin
    for (int k = 0; k < NUM_CROSS; k++) begin
      prod_nxt[2*k]     = PW'(diff[DIFF_PER_CRS*k])     * PW'(diff[DIFF_PER_CRS*k + 3]);
      prod_nxt[2*k + 1] = PW'(diff[DIFF_PER_CRS*k + 1]) * PW'(diff[DIFF_PER_CRS*k + 2]);
    end
  end

  // Two ordered intervals overlap when each low end is at most the other's
  // high end.
  always_comb begin
    ctrl_nxt.op    = up_op;
    ctrl_nxt.ovl_x = (lo[IV_X12] <= hi[IV_X34]) && (lo[IV_X34] <= hi[IV_X12]);
    ctrl_nxt.ovl_y = (lo[IV_Y12] <= hi[IV_Y34]) && (lo[IV_Y34] <= hi[IV_Y12]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r <= ctrl_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_ctrl  = ctrl_r;
  assign prod     = prod_r;

endmodule

// ===== hdl/sit_sign.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_sign: third pipeline stage
// Subtracts the partial products into the four cross products, reduces each
// to its sign, and compares the first two for the nonparallel test.
// ----------------------------------------------------------------------------
module sit_sign
  import sit_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  ctrl_t                  up_ctrl,
  input  logic signed [2*CB+1:0] prod [NUM_PROD],
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output sign_info_t             dn_info
);

  localparam int CW = 2 * CB + 3;

  logic                 load;
  logic                 v_r, v_nxt;
  sign_info_t           info_r, info_nxt;
  logic signed [CW-1:0] crs [NUM_CROSS];

  assign load     = !v_r || dn_ready;
  assign up_ready = load;
  assign v_nxt    = load ? up_valid : v_r;

  always_comb begin
    for (int k = 0; k < NUM_CROSS; k++) begin
      crs[k] = CW'(prod[2*k]) - CW'(prod[2*k + 1]);
    end
    for (int k = 0; k < NUM_CROSS; k++) begin
      if (crs[k] == '0) begin
        info_nxt.side[k] = SGN_ZERO;
      end else if (crs[k][CW-1]) begin
        info_nxt.side[k] = SGN_NEG;
      end else begin
        info_nxt.side[k] = SGN_POS;
      end
    end
    info_nxt.c12_eq = (crs[0] == crs[1]);
    info_nxt.ctrl   = up_ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      info_r <= info_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_info  = info_r;

  // Equal cross products must give equal signs.
  a_eq_same_sign: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && info_r.c12_eq |-> info_r.side[0] == info_r.side[1])
    else $error("sit_sign: equal cross products with different signs");

endmodule

// ===== hdl/segment_intersection_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test_top: streaming 2-D segment intersection test
// Four-stage pipeline that decides, per transaction, whether two segments or
// lines meet and reports the four orientation signs.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the result side is
// not stalled, and returns its result through the four register stages
// (coordinate differences, multipliers, cross product subtract and sign, hit
// decision in the output register). Each stage holds its own valid bit and
// accepts a new transaction whenever it is empty or its successor takes its
// content, so bubbles are squeezed out and a stall on the result side only
// backs up as far as it has to. All arithmetic is exact two's complement: the
// cross products are carried at 2*COORD_BITS+3 bits, so nothing saturates or
// rounds. The four sign fields are valid for every operation; the hit flag
// follows the operation carried in in_tuser. There is no configuration and
// no state that outlives a transaction.
// ----------------------------------------------------------------------------
module segment_intersection_test_top
  import sit_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // Fields from bit 0 up: p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
  // each COORD_BITS wide and signed.
  input  logic [8*COORD_BITS-1:0]   in_tdata,
  // Fields from bit 0 up: operation (2 bits).
  input  logic [IN_TUSER_W-1:0]     in_tuser,
  // Result channel.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // Fields from bit 0 up: hit (1), side_p1 (2), side_p2 (2), side_p3 (2),
  // side_p4 (2), then zero fill to 16 bits.
  output logic [OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CB = COORD_BITS;

  // Unpacked coordinates; point j sits at field 2*j (x) and 2*j+1 (y).
  logic signed [CB-1:0] in_px [NUM_PTS];
  logic signed [CB-1:0] in_py [NUM_PTS];

  always_comb begin
    for (int j = 0; j < NUM_PTS; j++) begin
      in_px[j] = in_tdata[CB*(2*j)     +: CB];
      in_py[j] = in_tdata[CB*(2*j + 1) +: CB];
    end
  end

  // Stage 1: differences and interval bounds.
  logic                 s1_valid, s1_ready;
  op_t                  s1_op;
  logic signed [CB:0]   s1_diff [NUM_DIFF];
  logic signed [CB-1:0] s1_lo   [NUM_IV];
  logic signed [CB-1:0] s1_hi   [NUM_IV];

  sit_diff #(
    .CB (CB)
  ) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_op    (op_t'(in_tuser)),
    .pt_x     (in_px),
    .pt_y     (in_py),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_op    (s1_op),
    .diff     (s1_diff),
    .lo       (s1_lo),
    .hi       (s1_hi)
  );

  // Stage 2: partial products and overlap flags.
  logic                   s2_valid, s2_ready;
  ctrl_t                  s2_ctrl;
  logic signed [2*CB+1:0] s2_prod [NUM_PROD];

  sit_mult #(
    .CB (CB)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_op    (s1_op),
    .diff     (s1_diff),
    .lo       (s1_lo),
    .hi       (s1_hi),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_ctrl  (s2_ctrl),
    .prod     (s2_prod)
  );

  // Stage 3: cross products reduced to signs.
  logic       s3_valid, s3_ready;
  sign_info_t s3_info;

  sit_sign #(
    .CB (CB)
  ) u_sign (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_ctrl  (s2_ctrl),
    .prod     (s2_prod),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_info  (s3_info)
  );

  // Stage 4: the hit decision goes straight into the output register.
  // A pair of signs has a product of at most zero unless both are nonzero
  // and equal, and a product below zero when one is positive and the other
  // negative.
  logic                   out_load;
  logic                   ov_r, ov_nxt;
  logic [OUT_TDATA_W-1:0] od_r, od_nxt;
  logic                   le12, le34, lt12, lt34;
  logic                   hit;

  assign out_load = !ov_r || out_tready;
  assign s3_ready = out_load;
  assign ov_nxt   = out_load ? s3_valid : ov_r;

  always_comb begin
    le12 = !(((s3_info.side[0] == SGN_POS) && (s3_info.side[1] == SGN_POS)) ||
             ((s3_info.side[0] == SGN_NEG) && (s3_info.side[1] == SGN_NEG)));
    le34 = !(((s3_info.side[2] == SGN_POS) && (s3_info.side[3] == SGN_POS)) ||
             ((s3_info.side[2] == SGN_NEG) && (s3_info.side[3] == SGN_NEG)));
    lt12 = ((s3_info.side[0] == SGN_POS) && (s3_info.side[1] == SGN_NEG)) ||
           ((s3_info.side[0] == SGN_NEG) && (s3_info.side[1] == SGN_POS));
    lt34 = ((s3_info.side[2] == SGN_POS) && (s3_info.side[3] == SGN_NEG)) ||
           ((s3_info.side[2] == SGN_NEG) && (s3_info.side[3] == SGN_POS));
    case (s3_info.ctrl.op)
      OP_SEG_INCL:   hit = s3_info.ctrl.ovl_x && s3_info.ctrl.ovl_y && le12 && le34;
      OP_SEG_STRICT: hit = lt12 && lt34;
      OP_LINE_SEG:   hit = le34;
      default:       hit = !s3_info.c12_eq;
    endcase
    od_nxt = {7'd0, s3_info.side[3], s3_info.side[2], s3_info.side[1],
              s3_info.side[0], hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      od_r <= od_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // The input side can only be held off when every stage is full and the
  // result side is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("top: input stalled while the pipeline has room");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("top: result presented right after reset");

endmodule
